// ===== rtl/srr_pkg.sv =====
// Shared constants, types and codes for the selective repeat receiver.
package srr_pkg;

  // Sequence space, window and stored payload width
  localparam int SEQ_BITS     = 3;
  localparam int SEQ_MOD      = 1 << SEQ_BITS;
  localparam int WINDOW       = 4;
  localparam int PAYLOAD_BITS = 64;
  localparam int WORD_BITS    = 64;

  // Deliveries released by one packet at most
  localparam int DELIVER_CAP  = (WINDOW < SEQ_MOD) ? WINDOW : SEQ_MOD;
  localparam int CNT_BITS     = $clog2(DELIVER_CAP + 1);

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] pld_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;

  // Result kind codes
  typedef enum logic {
    KIND_DELIVER = 1'b0,
    KIND_ACK     = 1'b1
  } kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ACK
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic deliver;
    logic ack;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_valid;
    logic in_ok;
    logic base_filled;
    logic cap_hit;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/srr_if.sv =====
// Packet and result channel interfaces with valid/ready handshake.
interface srr_pkt_if;
  import srr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 checksum_ok;
  logic [SEQ_BITS-1:0]  seq_num;
  logic [WORD_BITS-1:0] payload;

  modport source (output valid, checksum_ok, seq_num, payload, input ready);
  modport sink   (input valid, checksum_ok, seq_num, payload, output ready);
endinterface

interface srr_res_if;
  import srr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [WORD_BITS-1:0] data_out;
  logic [SEQ_BITS-1:0]  ack_num;
  logic                 last;

  modport source (output valid, kind, data_out, ack_num, last, input ready);
  modport sink   (input valid, kind, data_out, ack_num, last, output ready);
endinterface

// ===== rtl/selective_repeat_receiver.sv =====
// Top level of the selective repeat receiver.
//
//   channel  dir  beat contents
//   pkt      in   checksum_ok, seq_num, payload
//   res      out  kind, data_out, ack_num, last
//
// A good packet visits CHECK, then READ and CHECK once per in-order delivery it
// releases (0 to 4), then ACK, which loads its ack before the input opens again
// in IDLE; the registered read of the payload buffer is why each delivery takes
// both a CHECK and a READ state.
// A corrupt packet is dropped in the cycle it is accepted.
// Reset (rst, synchronous) clears the window base, slot flags and state.
// A stalled res holds the controller; the next packet is taken while the ack waits.
module selective_repeat_receiver (
  input  logic      clk,
  input  logic      rst,
  srr_pkt_if.sink   pkt,
  srr_res_if.source res
);
  import srr_pkg::*;

  cmd_t    cmd;
  status_t status;

  srr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  srr_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .pkt    (pkt),
    .res    (res),
    .cmd    (cmd),
    .status (status)
  );

endmodule

// ===== rtl/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srr_ctrl.sv =====
// Controller state machine: accept a packet, drain the in-order run, then ack.
module srr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  srr_pkg::status_t status,
  output srr_pkg::cmd_t    cmd
);
  import srr_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (status.in_valid && status.in_ok) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.base_filled && !status.cap_hit) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_ACK;
        end
      end
      ST_READ: begin
        if (status.out_free) begin
          state_next = ST_CHECK;
        end
      end
      ST_ACK: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:  cmd.in_ready = 1'b1;
      ST_CHECK: cmd = '0;
      ST_READ:  cmd.deliver  = status.out_free;
      ST_ACK:   cmd.ack      = status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== rtl/srr_dp.sv =====
// Datapath: window base, slot flags, payload buffer and result register.
module srr_dp (
  input  logic              clk,
  input  logic              rst,
  srr_pkt_if.sink           pkt,
  srr_res_if.source         res,
  input  srr_pkg::cmd_t     cmd,
  output srr_pkg::status_t  status
);
  import srr_pkg::*;

  seq_t                 base;
  logic [SEQ_MOD-1:0]   filled;
  cnt_t                 count;
  seq_t                 seq_hold;
  logic                 pkt_beat;
  logic                 in_window;
  seq_t                 offset;
  logic                 store;
  pld_t                 rd_word;
  logic                 out_valid;
  logic                 out_free;
  logic                 out_kind;
  logic [WORD_BITS-1:0] out_data;
  seq_t                 out_ack;
  logic                 out_last;

  // Window test on the arriving sequence number
  assign pkt.ready = cmd.in_ready;
  assign pkt_beat  = pkt.valid && cmd.in_ready;
  assign offset    = pkt.seq_num - base;
  assign in_window = (32'(offset) < WINDOW);
  assign store     = pkt_beat && pkt.checksum_ok && in_window;

  // Payload buffer, read always at the window base
  srr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_MOD)
  ) u_ram (
    .clk   (clk),
    .we    (store),
    .waddr (pkt.seq_num),
    .wdata (pkt.payload[PAYLOAD_BITS-1:0]),
    .raddr (base),
    .rdata (rd_word)
  );

  // Window base, slot flags and delivery count
  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      filled <= '0;
      count  <= '0;
    end else begin
      if (store) begin
        filled[pkt.seq_num] <= 1'b1;
      end
      if (pkt_beat) begin
        count <= '0;
      end else if (cmd.deliver) begin
        filled[base] <= 1'b0;
        base         <= base + 1'b1;
        count        <= count + 1'b1;
      end
    end
  end

  // Hold the sequence number for the ack
  always_ff @(posedge clk) begin
    if (pkt_beat) begin
      seq_hold <= pkt.seq_num;
    end
  end

  // Result register: load a beat when free, drop it when taken
  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver || cmd.ack) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_kind <= KIND_DELIVER;
      out_data <= WORD_BITS'(rd_word);
      out_ack  <= '0;
      out_last <= 1'b0;
    end else if (cmd.ack) begin
      out_kind <= KIND_ACK;
      out_data <= '0;
      out_ack  <= seq_hold;
      out_last <= 1'b1;
    end
  end

  assign res.valid    = out_valid;
  assign res.kind     = out_kind;
  assign res.data_out = out_data;
  assign res.ack_num  = out_ack;
  assign res.last     = out_last;

  // Status to the controller
  assign status.in_valid    = pkt.valid;
  assign status.in_ok       = pkt.checksum_ok;
  assign status.base_filled = filled[base];
  assign status.cap_hit     = (32'(count) >= DELIVER_CAP);
  assign status.out_free    = out_free;

endmodule

// ===== verif/selective_repeat_receiver_test.sv =====
// Self-checking testbench for the selective repeat receiver: directed table, then random packets.
module selective_repeat_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srr_pkg::*;

  localparam int GOOD_PACKETS = 440;
  localparam int QUIET_TAIL   = 60;
  localparam int HOLD_AT      = 150;
  localparam int DRAIN_AT     = 300;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 20;
  localparam int IDLE_LIMIT   = 3000;
  localparam int REPORT_MAX   = 10;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] ALL_ZERO = '0;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ACK,
    CHK_DELIVER_ACK
  } check_mode_t;

  typedef struct packed {
    logic                 ok;
    seq_t                 seq;
    logic [WORD_BITS-1:0] payload;
    check_mode_t          mode;
  } probe_t;

  typedef struct packed {
    kind_t                kind;
    logic [WORD_BITS-1:0] data;
    seq_t                 ack;
    logic                 last;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  srr_pkt_if pkt_ch ();
  srr_res_if res_ch ();

  selective_repeat_receiver i_dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_ch),
    .res (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receive window as seen from outside
  seq_t              rx_base;
  logic              rx_filled [SEQ_MOD];
  pld_t              rx_word   [SEQ_MOD];
  result_t           released[$];
  result_t           pending_results[$];

  int unsigned       fail_count    = 0;
  bit                long_hold_req = 1'b0;
  bit                quiet_tail    = 1'b0;
  int unsigned       tx_gap_pct    = 0;

  // Window base walks 0 -> 1 -> 5 -> 1 -> 2 -> 3 -> 5 through this table
  probe_t directed [20] = '{
    '{1'b0, 3'd0, ALL_ONES,                CHK_NONE},
    '{1'b1, 3'd0, ALL_ONES,                CHK_DELIVER_ACK},
    '{1'b1, 3'd0, ALL_ZERO,                CHK_ACK},
    '{1'b1, 3'd5, ALL_ZERO,                CHK_ACK},
    '{1'b1, 3'd7, 64'h5555_5555_5555_5555, CHK_ACK},
    '{1'b1, 3'd3, 64'hAAAA_AAAA_AAAA_AAAA, CHK_ACK},
    '{1'b1, 3'd3, 64'h0000_0000_0000_0001, CHK_ACK},
    '{1'b1, 3'd4, 64'h8000_0000_0000_0000, CHK_ACK},
    '{1'b0, 3'd1, ALL_ONES,                CHK_NONE},
    '{1'b1, 3'd2, 64'h0123_4567_89AB_CDEF, CHK_ACK},
    '{1'b1, 3'd1, 64'hFEDC_BA98_7654_3210, CHK_MODEL},
    '{1'b1, 3'd6, 64'h1111_2222_3333_4444, CHK_ACK},
    '{1'b1, 3'd7, ALL_ONES,                CHK_ACK},
    '{1'b1, 3'd0, 64'h7FFF_FFFF_FFFF_FFFE, CHK_ACK},
    '{1'b1, 3'd5, 64'hDEAD_BEEF_CAFE_F00D, CHK_MODEL},
    '{1'b1, 3'd1, ALL_ZERO,                CHK_DELIVER_ACK},
    '{1'b1, 3'd4, ALL_ONES,                CHK_ACK},
    '{1'b1, 3'd2, ALL_ZERO,                CHK_DELIVER_ACK},
    '{1'b1, 3'd3, 64'h0000_0000_0000_0005, CHK_MODEL},
    '{1'b1, 3'd1, ALL_ONES,                CHK_ACK}
  };

  // Buffer one packet and collect the deliveries and ack it releases
  function automatic void absorb_packet(input logic ok, input seq_t seq,
                                        input logic [WORD_BITS-1:0] payload);
    seq_t offset;
    int   count = 0;
    released.delete();
    if (!ok)
      return;
    offset = seq - rx_base;
    if (offset < WINDOW) begin
      rx_filled[seq] = 1'b1;
      rx_word[seq]   = payload[PAYLOAD_BITS-1:0];
      while (count < DELIVER_CAP && rx_filled[rx_base]) begin
        rx_filled[rx_base] = 1'b0;
        released.push_back('{KIND_DELIVER, WORD_BITS'(rx_word[rx_base]), '0, 1'b0});
        count++;
        rx_base++;
      end
    end
    released.push_back('{KIND_ACK, ALL_ZERO, seq, 1'b1});
  endfunction

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s: kind/data/ack/last expected %0d/%h/%0d/%0b, got %0d/%h/%0d/%0b",
               $realtime, what, want.kind, want.data, want.ack, want.last,
               got.kind, got.data, got.ack, got.last);
  endfunction

  // Offer one packet and hold it until the block takes the beat
  task automatic send_packet(input logic ok, input seq_t seq,
                             input logic [WORD_BITS-1:0] payload);
    pkt_ch.valid       <= 1'b1;
    pkt_ch.checksum_ok <= ok;
    pkt_ch.seq_num     <= seq;
    pkt_ch.payload     <= payload;
    do
      @(posedge clk);
    while (!pkt_ch.ready);
    absorb_packet(ok, seq, payload);
  endtask

  // Drop valid for a random burst now and then
  task automatic maybe_gap();
    if (!quiet_tail && $urandom_range(0, 99) < tx_gap_pct) begin
      pkt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic logic [WORD_BITS-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return ALL_ZERO;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sender
  initial begin
    int unsigned good_sent;
    int unsigned n_item;
    int unsigned r;
    logic        ok;
    seq_t        seq;

    good_sent          = 0;
    n_item             = 0;
    rst                <= 1'b1;
    pkt_ch.valid       <= 1'b0;
    pkt_ch.checksum_ok <= 1'b0;
    pkt_ch.seq_num     <= '0;
    pkt_ch.payload     <= '0;
    rx_base = '0;
    foreach (rx_filled[i]) begin
      rx_filled[i] = 1'b0;
      rx_word[i]   = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    tx_gap_pct = 30;
    foreach (directed[i]) begin
      send_packet(directed[i].ok, directed[i].seq, directed[i].payload);
      case (directed[i].mode)
        CHK_MODEL: begin
          foreach (released[k])
            pending_results.push_back(released[k]);
        end
        CHK_ACK: begin
          pending_results.push_back('{KIND_ACK, ALL_ZERO, directed[i].seq, 1'b1});
        end
        CHK_DELIVER_ACK: begin
          pending_results.push_back('{KIND_DELIVER,
                                      WORD_BITS'(directed[i].payload[PAYLOAD_BITS-1:0]),
                                      '0, 1'b0});
          pending_results.push_back('{KIND_ACK, ALL_ZERO, directed[i].seq, 1'b1});
        end
        default: begin
        end
      endcase
      if (directed[i].ok)
        good_sent++;
      maybe_gap();
    end

    // Random traffic, mostly a sender working inside the window
    while (good_sent < GOOD_PACKETS) begin
      if (n_item % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_gap_pct = 0;
          1:       tx_gap_pct = 25;
          default: tx_gap_pct = 60;
        endcase
      end
      if (n_item == HOLD_AT) begin
        long_hold_req = 1'b1;
        tx_gap_pct    = 0;
      end
      if (n_item == DRAIN_AT) begin
        pkt_ch.valid <= 1'b0;
        do
          @(posedge clk);
        while (pending_results.size() != 0);
      end
      quiet_tail = (good_sent >= GOOD_PACKETS - QUIET_TAIL);

      r   = $urandom_range(0, 99);
      ok  = (r >= 8);
      if (r < 75)
        seq = rx_base + seq_t'($urandom_range(0, WINDOW - 1));
      else
        seq = seq_t'($urandom);
      send_packet(ok, seq, pick_payload());
      foreach (released[k])
        pending_results.push_back(released[k]);
      if (ok)
        good_sent++;
      n_item++;
      maybe_gap();
    end

    // Drain and let the block settle
    pkt_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Receiver: check each result beat, stall in bursts
  initial begin
    int unsigned rx_stall;
    int unsigned rx_gap_pct;
    int unsigned cyc;
    result_t     got;
    result_t     want;

    rx_stall     = 0;
    rx_gap_pct   = 0;
    cyc          = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got = '{kind_t'(res_ch.kind), res_ch.data_out, res_ch.ack_num, res_ch.last};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got != want)
            report_mismatch("mismatch", want, got);
        end
      end

      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_gap_pct = 0;
          1:       rx_gap_pct = 20;
          default: rx_gap_pct = 50;
        endcase
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_stall      = LONG_HOLD;
      end

      if (rx_stall > 0) begin
        rx_stall--;
        res_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < rx_gap_pct) begin
        rx_stall = $urandom_range(0, 15);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== selective_repeat_receiver.f =====
rtl/srr_pkg.sv
rtl/srr_if.sv
rtl/srr_ram.sv
rtl/srr_ctrl.sv
rtl/srr_dp.sv
rtl/selective_repeat_receiver.sv
verif/selective_repeat_receiver_test.sv
